/* src/zlw_pkg.sv */
`timescale 1ns / 1ps

package zlw_pkg;

   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_RECORD = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [31:0] HDR_MAGIC  = 32'h04034b50;
   localparam logic [31:0] DESC_MAGIC = 32'h08074b50;
   localparam logic [15:0] DESC_FLAG  = 16'h0008;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  name_byte;
      logic [15:0] method;
      logic [31:0] data_offset;
      logic [31:0] compressed_size;
      logic [31:0] uncompressed_size;
      logic        last_of_run;
   } rsp_item_type;

endpackage

/* src/zlw_req_intf.sv */
`timescale 1ns / 1ps

interface zlw_req_intf;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/zlw_rsp_intf.sv */
`timescale 1ns / 1ps

interface zlw_rsp_intf;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  name_byte;
   logic [15:0] method;
   logic [31:0] data_offset;
   logic [31:0] compressed_size;
   logic [31:0] uncompressed_size;
   logic        last_of_run;

   modport source (output valid, output result_kind, output name_byte, output method,
                   output data_offset, output compressed_size,
                   output uncompressed_size, output last_of_run, input ready);
   modport sink (input valid, input result_kind, input name_byte, input method,
                 input data_offset, input compressed_size,
                 input uncompressed_size, input last_of_run, output ready);
endinterface

/* src/zip_local_header_walker.sv */
// Results of an accepted byte are queued, then offered on rsp_ch; the walker state
// is updated in the accepting cycle. Throughput: one byte per cycle while fewer than
// three results wait; a byte may give two results (the final byte), and a
// four-entry result queue keeps the input open while results wait.
// Reset (synchronous, active high) clears the walker state and empties the queue.
`timescale 1ns / 1ps

module zip_local_header_walker (
   input  logic       clock,
   input  logic       reset,
   zlw_req_intf.sink  req_ch,
   zlw_rsp_intf.source rsp_ch
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_NAME   = 3'd1;
   localparam logic [2:0] PH_EXTRA  = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_SCAN   = 3'd4;
   localparam logic [2:0] PH_DESC   = 3'd5;

   localparam int QUEUE_DEPTH = 4;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  field_index_ff, field_index_in;
   logic [15:0] header_flags_ff, header_flags_in;
   logic [15:0] method_reg_ff, method_reg_in;
   logic [31:0] size_packed_ff, size_packed_in;
   logic [31:0] size_unpacked_ff, size_unpacked_in;
   logic [15:0] name_length_ff, name_length_in;
   logic [15:0] extra_length_ff, extra_length_in;
   logic [31:0] skip_count_ff, skip_count_in;
   logic [31:0] byte_position_ff, byte_position_in;
   logic [31:0] magic_window_ff, magic_window_in;
   logic        finished_ff, finished_in;

   zlw_pkg::rsp_item_type queue_ff [QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [2:0] count_ff, count_in;

   zlw_pkg::rsp_item_type res0, res1;
   logic [1:0]  n_res;
   logic        accept, pop, stop, name_done, go_data, boundary;
   logic [7:0]  b;
   logic [31:0] offset;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign b = req_ch.data_byte;
   assign wr_next = wr_ptr_ff + 2'd1;

   // keep room for the two results one byte can give
   assign req_ch.ready = (count_ff < 3'd3);

   always_comb begin
      phase_in = phase_ff;
      field_index_in = field_index_ff;
      header_flags_in = header_flags_ff;
      method_reg_in = method_reg_ff;
      size_packed_in = size_packed_ff;
      size_unpacked_in = size_unpacked_ff;
      name_length_in = name_length_ff;
      extra_length_in = extra_length_ff;
      skip_count_in = skip_count_ff;
      byte_position_in = byte_position_ff;
      magic_window_in = magic_window_ff;
      finished_in = finished_ff;
      res0 = '0;
      res1 = '0;
      n_res = 2'd0;
      stop = 1'b0;
      name_done = 1'b0;
      go_data = 1'b0;
      boundary = 1'b0;
      offset = '0;

      if (accept && !finished_ff) begin
         byte_position_in = byte_position_ff + 32'd1;
         unique case (phase_ff)
            PH_HEADER: begin
               if (field_index_ff < 5'd4 &&
                   b != zlw_pkg::HDR_MAGIC[{field_index_ff[1:0], 3'b000} +: 8]) begin
                  res0.result_kind = zlw_pkg::KIND_END;
                  n_res = 2'd1;
                  finished_in = 1'b1;
                  stop = 1'b1;
               end else begin
                  unique case (field_index_ff)
                     5'd6, 5'd7:
                        header_flags_in = {b, header_flags_ff[15:8]};
                     5'd8, 5'd9:
                        method_reg_in = {b, method_reg_ff[15:8]};
                     5'd18, 5'd19, 5'd20, 5'd21:
                        size_packed_in = {b, size_packed_ff[31:8]};
                     5'd22, 5'd23, 5'd24, 5'd25:
                        size_unpacked_in = {b, size_unpacked_ff[31:8]};
                     5'd26, 5'd27:
                        name_length_in = {b, name_length_ff[15:8]};
                     5'd28, 5'd29:
                        extra_length_in = {b, extra_length_ff[15:8]};
                     default: ;
                  endcase
                  if (field_index_ff >= 5'd29) begin
                     field_index_in = '0;
                     offset = byte_position_ff + 32'd1 + {16'd0, name_length_in}
                              + {16'd0, extra_length_in};
                     if ((header_flags_in & zlw_pkg::DESC_FLAG) != '0) begin
                        skip_count_in = offset;
                     end else begin
                        skip_count_in = size_packed_in;
                        res0.result_kind = zlw_pkg::KIND_RECORD;
                        res0.method = method_reg_in;
                        res0.data_offset = offset;
                        res0.compressed_size = size_packed_in;
                        res0.uncompressed_size = size_unpacked_in;
                        n_res = 2'd1;
                     end
                     if (name_length_in != '0) begin
                        phase_in = PH_NAME;
                     end else begin
                        name_done = 1'b1;
                     end
                  end else begin
                     field_index_in = field_index_ff + 5'd1;
                  end
               end
            end
            PH_NAME: begin
               res0.result_kind = zlw_pkg::KIND_NAME;
               res0.name_byte = b;
               n_res = 2'd1;
               name_length_in = name_length_ff - 16'd1;
               if (name_length_in == '0) begin
                  name_done = 1'b1;
               end
            end
            PH_EXTRA: begin
               extra_length_in = extra_length_ff - 16'd1;
               if (extra_length_in == '0) begin
                  go_data = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_count_in = skip_count_ff - 32'd1;
               if (skip_count_in == '0) begin
                  phase_in = PH_HEADER;
                  field_index_in = '0;
               end
            end
            PH_SCAN: begin
               magic_window_in = {b, magic_window_ff[31:8]};
               if (magic_window_in == zlw_pkg::DESC_MAGIC) begin
                  phase_in = PH_DESC;
                  field_index_in = '0;
               end
            end
            PH_DESC: begin
               if (field_index_ff >= 5'd4 && field_index_ff <= 5'd7) begin
                  size_packed_in = {b, size_packed_ff[31:8]};
               end else if (field_index_ff >= 5'd8 && field_index_ff <= 5'd11) begin
                  size_unpacked_in = {b, size_unpacked_ff[31:8]};
               end
               if (field_index_ff >= 5'd11) begin
                  res0.result_kind = zlw_pkg::KIND_RECORD;
                  res0.method = method_reg_ff;
                  res0.data_offset = skip_count_ff;
                  res0.compressed_size = size_packed_in;
                  res0.uncompressed_size = size_unpacked_in;
                  n_res = 2'd1;
                  phase_in = PH_HEADER;
                  field_index_in = '0;
               end else begin
                  field_index_in = field_index_ff + 5'd1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
               field_index_in = '0;
            end
         endcase

         // after the name: skip the extra field, else enter the data
         if (name_done) begin
            if (extra_length_in != '0) begin
               phase_in = PH_EXTRA;
            end else begin
               go_data = 1'b1;
            end
         end
         if (go_data) begin
            if ((header_flags_in & zlw_pkg::DESC_FLAG) != '0) begin
               phase_in = PH_SCAN;
               magic_window_in = '0;
            end else if (skip_count_in != '0) begin
               phase_in = PH_SKIP;
            end else begin
               phase_in = PH_HEADER;
               field_index_in = '0;
            end
         end

         if (!stop && req_ch.last_byte) begin
            boundary = (phase_in == PH_HEADER && field_index_in == '0) ||
                       (phase_in == PH_SKIP);
            finished_in = 1'b1;
            if (n_res == 2'd0) begin
               res0.result_kind = boundary ? zlw_pkg::KIND_END : zlw_pkg::KIND_ERROR;
               n_res = 2'd1;
            end else begin
               res1.result_kind = boundary ? zlw_pkg::KIND_END : zlw_pkg::KIND_ERROR;
               n_res = 2'd2;
            end
         end

         if (n_res == 2'd2) begin
            res1.last_of_run = 1'b1;
         end else begin
            res0.last_of_run = 1'b1;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_res;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, n_res} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         field_index_ff <= '0;
         header_flags_ff <= '0;
         method_reg_ff <= '0;
         size_packed_ff <= '0;
         size_unpacked_ff <= '0;
         name_length_ff <= '0;
         extra_length_ff <= '0;
         skip_count_ff <= '0;
         byte_position_ff <= '0;
         magic_window_ff <= '0;
         finished_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         field_index_ff <= field_index_in;
         header_flags_ff <= header_flags_in;
         method_reg_ff <= method_reg_in;
         size_packed_ff <= size_packed_in;
         size_unpacked_ff <= size_unpacked_in;
         name_length_ff <= name_length_in;
         extra_length_ff <= extra_length_in;
         skip_count_ff <= skip_count_in;
         byte_position_ff <= byte_position_in;
         magic_window_ff <= magic_window_in;
         finished_ff <= finished_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_next] <= res1;
      end
   end

   assign rsp_ch.valid = (count_ff != '0);
   assign rsp_ch.result_kind = queue_ff[rd_ptr_ff].result_kind;
   assign rsp_ch.name_byte = queue_ff[rd_ptr_ff].name_byte;
   assign rsp_ch.method = queue_ff[rd_ptr_ff].method;
   assign rsp_ch.data_offset = queue_ff[rd_ptr_ff].data_offset;
   assign rsp_ch.compressed_size = queue_ff[rd_ptr_ff].compressed_size;
   assign rsp_ch.uncompressed_size = queue_ff[rd_ptr_ff].uncompressed_size;
   assign rsp_ch.last_of_run = queue_ff[rd_ptr_ff].last_of_run;

endmodule

/* src/zlw_checker.sv */
`timescale 1ns / 1ps

module zlw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   logic stopped_ff, stopped_in;

   // remember that the walker has delivered its end or error item
   assign stopped_in = stopped_ff || (rsp_valid && rsp_ready &&
                       (rsp_kind == zlw_pkg::KIND_END || rsp_kind == zlw_pkg::KIND_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("result item changed while stalled");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == zlw_pkg::KIND_END || rsp_kind == zlw_pkg::KIND_ERROR)
      |-> rsp_last)
      else $error("end or error item not marked last of run");

   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !rsp_valid)
      else $error("item offered after archive end or error");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind zip_local_header_walker zlw_checker u_zlw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.result_kind),
   .rsp_last  (rsp_ch.last_of_run)
);

/* dv/zip_local_header_walker_tb.sv */
`timescale 1ns / 1ps

module zip_local_header_walker_tb;

   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [2:0] {
      WALK_HEADER, WALK_NAME, WALK_EXTRA, WALK_SKIP, WALK_SCAN, WALK_DESC
   } walk_phase_type;

   class walker_scoreboard;
      walk_phase_type phase     = WALK_HEADER;
      logic [4:0]   field_idx   = '0;
      logic [15:0]  flags       = '0;
      logic [15:0]  method_code = '0;
      logic [31:0]  packed_size = '0;
      logic [31:0]  plain_size  = '0;
      logic [15:0]  name_left   = '0;
      logic [15:0]  extra_left  = '0;
      logic [31:0]  skip_left   = '0;
      logic [31:0]  position    = '0;
      logic [31:0]  window      = '0;
      bit           stopped     = 1'b0;
      zlw_pkg::rsp_item_type due_results[$];
      int           mismatches  = 0;

      function zlw_pkg::rsp_item_type make_result(logic [1:0] kind, logic [7:0] nb,
                                                  logic [15:0] meth, logic [31:0] off,
                                                  logic [31:0] cs, logic [31:0] us);
         zlw_pkg::rsp_item_type r;
         r = '0;
         r.result_kind       = kind;
         r.name_byte         = nb;
         r.method            = meth;
         r.data_offset       = off;
         r.compressed_size   = cs;
         r.uncompressed_size = us;
         return r;
      endfunction

      function void enter_data();
         if ((flags & zlw_pkg::DESC_FLAG) != 0) begin
            phase  = WALK_SCAN;
            window = '0;
         end else if (skip_left != 0) begin
            phase = WALK_SKIP;
         end else begin
            phase     = WALK_HEADER;
            field_idx = '0;
         end
      endfunction

      function void leave_name();
         if (extra_left != 0) phase = WALK_EXTRA;
         else enter_data();
      endfunction

      function void note_byte(logic [7:0] b, logic at_end);
         zlw_pkg::rsp_item_type run [2];
         int           n;
         logic [31:0]  pos;
         logic [31:0]  off;
         logic [4:0]   i;
         n = 0;
         if (stopped) return;
         pos      = position;
         position = pos + 32'd1;
         case (phase)
            WALK_HEADER: begin
               i = field_idx;
               if (i < 5'd4 && b != zlw_pkg::HDR_MAGIC[8*i +: 8]) begin
                  // wrong magic ends the archive, last_byte or not
                  run[0]  = make_result(zlw_pkg::KIND_END, '0, '0, '0, '0, '0);
                  n       = 1;
                  stopped = 1'b1;
               end else begin
                  if (i == 5'd6 || i == 5'd7) flags = {b, flags[15:8]};
                  else if (i == 5'd8 || i == 5'd9) method_code = {b, method_code[15:8]};
                  else if (i >= 5'd18 && i <= 5'd21) packed_size = {b, packed_size[31:8]};
                  else if (i >= 5'd22 && i <= 5'd25) plain_size = {b, plain_size[31:8]};
                  else if (i == 5'd26 || i == 5'd27) name_left = {b, name_left[15:8]};
                  else if (i == 5'd28 || i == 5'd29) extra_left = {b, extra_left[15:8]};
                  if (i == 5'd29) begin
                     field_idx = '0;
                     off = pos + 32'd1 + name_left + extra_left;
                     // descriptor entries hold the offset until the descriptor is read
                     if ((flags & zlw_pkg::DESC_FLAG) != 0) begin
                        skip_left = off;
                     end else begin
                        skip_left = packed_size;
                        run[0] = make_result(zlw_pkg::KIND_RECORD, '0, method_code, off,
                                             packed_size, plain_size);
                        n = 1;
                     end
                     if (name_left != 0) phase = WALK_NAME;
                     else leave_name();
                  end else begin
                     field_idx = i + 5'd1;
                  end
               end
            end
            WALK_NAME: begin
               run[0]    = make_result(zlw_pkg::KIND_NAME, b, '0, '0, '0, '0);
               n         = 1;
               name_left = name_left - 16'd1;
               if (name_left == 0) leave_name();
            end
            WALK_EXTRA: begin
               extra_left = extra_left - 16'd1;
               if (extra_left == 0) enter_data();
            end
            WALK_SKIP: begin
               skip_left = skip_left - 32'd1;
               if (skip_left == 0) begin
                  phase     = WALK_HEADER;
                  field_idx = '0;
               end
            end
            WALK_SCAN: begin
               window = {b, window[31:8]};
               if (window == zlw_pkg::DESC_MAGIC) begin
                  phase     = WALK_DESC;
                  field_idx = '0;
               end
            end
            default: begin
               i = field_idx;
               if (i >= 5'd4 && i <= 5'd7) packed_size = {b, packed_size[31:8]};
               else if (i >= 5'd8 && i <= 5'd11) plain_size = {b, plain_size[31:8]};
               if (i >= 5'd11) begin
                  run[0] = make_result(zlw_pkg::KIND_RECORD, '0, method_code, skip_left,
                                       packed_size, plain_size);
                  n         = 1;
                  phase     = WALK_HEADER;
                  field_idx = '0;
               end else begin
                  field_idx = i + 5'd1;
               end
            end
         endcase
         if (!stopped && at_end) begin
            if ((phase == WALK_HEADER && field_idx == 0) || phase == WALK_SKIP)
               run[n] = make_result(zlw_pkg::KIND_END, '0, '0, '0, '0, '0);
            else
               run[n] = make_result(zlw_pkg::KIND_ERROR, '0, '0, '0, '0, '0);
            n++;
            stopped = 1'b1;
         end
         if (n > 0) run[n-1].last_of_run = 1'b1;
         for (int k = 0; k < n; k++) due_results.insert(due_results.size(), run[k]);
      endfunction

      function void report(string what, zlw_pkg::rsp_item_type want,
                           zlw_pkg::rsp_item_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t %s:", $time, what);
            $display("  expected kind %0d name %02h method %04h offset %08h cs %08h us %08h last %0b",
                     want.result_kind, want.name_byte, want.method, want.data_offset,
                     want.compressed_size, want.uncompressed_size, want.last_of_run);
            $display("  got      kind %0d name %02h method %04h offset %08h cs %08h us %08h last %0b",
                     got.result_kind, got.name_byte, got.method, got.data_offset,
                     got.compressed_size, got.uncompressed_size, got.last_of_run);
         end
      endfunction

      function void check_result(zlw_pkg::rsp_item_type got);
         zlw_pkg::rsp_item_type want;
         if (due_results.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = due_results.pop_front();
         if (got.result_kind !== want.result_kind || got.name_byte !== want.name_byte ||
             got.method !== want.method || got.data_offset !== want.data_offset ||
             got.compressed_size !== want.compressed_size ||
             got.uncompressed_size !== want.uncompressed_size ||
             got.last_of_run !== want.last_of_run)
            report("result mismatch", want, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   zlw_req_intf req_ch ();
   zlw_rsp_intf rsp_ch ();

   zip_local_header_walker dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   walker_scoreboard sb;
   logic [8:0]       archive_q[$];   // {last_byte, data_byte}
   int               seg_hdr, seg_name, seg_extra, seg_data, seg_desc, seg_end;
   int               src_idle_pct = 0;
   int               snk_idle_pct = 0;
   int               quiet_cycles = 0;

   function automatic void put_le(logic [31:0] v, int count);
      for (int j = 0; j < count; j++) archive_q.insert(archive_q.size(), {1'b0, v[8*j +: 8]});
   endfunction

   function automatic void append_entry(bit with_desc, logic [15:0] flag_bits,
                                        logic [15:0] meth, int name_len, int extra_len,
                                        int data_len, logic [31:0] hdr_usize,
                                        logic [31:0] desc_csize, logic [31:0] desc_usize,
                                        bit decoy);
      logic [15:0] f;
      logic [31:0] hdr_csize;
      f    = flag_bits;
      f[3] = with_desc;
      hdr_csize = with_desc ? $urandom : data_len;
      seg_hdr = archive_q.size();
      put_le(zlw_pkg::HDR_MAGIC, 4);
      put_le($urandom, 2);
      put_le(f, 2);
      put_le(meth, 2);
      put_le($urandom, 4);
      put_le($urandom, 4);
      put_le(hdr_csize, 4);
      put_le(hdr_usize, 4);
      put_le(name_len, 2);
      put_le(extra_len, 2);
      seg_name = archive_q.size();
      for (int j = 0; j < name_len; j++) put_le($urandom, 1);
      seg_extra = archive_q.size();
      for (int j = 0; j < extra_len; j++) put_le($urandom, 1);
      seg_data = archive_q.size();
      if (decoy) begin
         // near misses of the descriptor magic, overlapping the real one
         put_le(32'h00074b50, 4);
         put_le(32'h4b504b50, 4);
         put_le(32'h4b500707, 4);
         put_le(32'h00000007, 1);
      end
      for (int j = 0; j < data_len; j++) put_le($urandom, 1);
      seg_desc = archive_q.size();
      if (with_desc) begin
         put_le(zlw_pkg::DESC_MAGIC, 4);
         put_le($urandom, 4);
         put_le(desc_csize, 4);
         put_le(desc_usize, 4);
      end
      seg_end = archive_q.size();
   endfunction

   task automatic send_byte(logic [8:0] item);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= item[7:0];
      req_ch.last_byte <= item[8];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_byte(req_ch.data_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.result_kind, rsp_ch.name_byte, rsp_ch.method,
                             rsp_ch.data_offset, rsp_ch.compressed_size,
                             rsp_ch.uncompressed_size, rsp_ch.last_of_run});
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("zip_local_header_walker_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int          hold_idx;
      int          end_case;
      int          cut;
      int          total;
      bit          with_desc;
      int          name_len;
      logic [8:0]  t;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      sb = new;

      // directed entries: field extremes, both data modes, empty name/extra/data
      append_entry(1'b0, 16'hfff7, 16'hffff, 0, 0, 0, 32'hffffffff, '0, '0, 1'b0);
      append_entry(1'b0, 16'h0000, 16'h0000, 3, 2, 4, 32'h00000000, '0, '0, 1'b0);
      append_entry(1'b1, 16'h0000, 16'h0008, 1, 0, 0, 32'hffffffff,
                   32'hffffffff, 32'h00000000, 1'b1);
      append_entry(1'b1, 16'hffff, 16'h0000, 0, 0, 0, $urandom,
                   32'h00000000, 32'hffffffff, 1'b0);
      append_entry(1'b0, 16'h0000, 16'h0001, 0, 3, 0, $urandom, '0, '0, 1'b0);
      hold_idx = archive_q.size();

      while (archive_q.size() < 1600) begin
         with_desc = $urandom_range(0, 1);
         name_len  = ($urandom_range(0, 9) == 0) ? 0 :
                     ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 12);
         append_entry(with_desc, $urandom, ($urandom_range(0, 7) == 0) ? 16'h0 : $urandom,
                      name_len,
                      ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24),
                      $urandom, $urandom, $urandom, 1'b0);
      end

      // closing entry: cut it where the chosen ending happens
      end_case  = $urandom_range(0, 8);
      with_desc = (end_case == 5 || end_case == 6) ? 1'b1 :
                  (end_case == 1) ? 1'b0 : $urandom_range(0, 1);
      append_entry(with_desc, $urandom, $urandom, $urandom_range(1, 8),
                   $urandom_range(1, 4), $urandom_range(1, 16),
                   $urandom, $urandom, $urandom, 1'b0);
      case (end_case)
         0: cut = seg_end - 1;
         1: cut = $urandom_range(seg_data, seg_end - 1);
         2: cut = $urandom_range(seg_hdr, seg_name - 1);
         3: cut = $urandom_range(seg_name, seg_extra - 1);
         4: cut = $urandom_range(seg_extra, seg_data - 1);
         5: cut = $urandom_range(seg_data, seg_desc + 2);
         6: cut = $urandom_range(seg_desc + 3, seg_end - 2);
         default: begin
            cut = seg_hdr + $urandom_range(0, 3);
            t   = archive_q[cut];
            t[7:0] = t[7:0] ^ $urandom_range(1, 255);
            archive_q[cut] = t;
         end
      endcase
      while (archive_q.size() > cut + 1) void'(archive_q.pop_back());
      if (end_case != 7) begin
         t    = archive_q[cut];
         t[8] = 1'b1;
         archive_q[cut] = t;
      end
      // trailing bytes after the end must be ignored
      repeat ($urandom_range(4, 16)) begin
         t = $urandom;
         archive_q.insert(archive_q.size(), t);
      end
      total = archive_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < total; k++) begin
         if (k == hold_idx) begin
            // hold input until the walker has drained
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (sb.due_results.size() != 0) @(posedge clock);
         end
         if (k < total / 3) begin
            src_idle_pct = 10;
            snk_idle_pct = 62;
         end else if (k < 2 * total / 3) begin
            src_idle_pct = 62;
            snk_idle_pct = 10;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         send_byte(archive_q[k]);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_results.size() == 0)
         $display("zip_local_header_walker_tb: PASS");
      else
         $display("zip_local_header_walker_tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
src/zlw_pkg.sv
src/zlw_req_intf.sv
src/zlw_rsp_intf.sv
src/zip_local_header_walker.sv
src/zlw_checker.sv
dv/zip_local_header_walker_tb.sv
